// ===== rtl/core/tbsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tbsm_pkg
// Shared types, codes and constants of the transmit buffer slot manager.
// ----------------------------------------------------------------------------
package tbsm_pkg;

    localparam int SLOT_COUNT_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TIME_W     = 32;
    localparam int FAIL_W     = 8;

    localparam logic [FAIL_W-1:0] MAX_FAIL_RST = 8'd3;
    localparam logic [TIME_W-1:0] MAX_IDLE_RST = 32'd1000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAIL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDLE = 2'd1;

    // Operation codes carried in the mode field of a request.
    localparam logic [2:0] MODE_ALLOC = 3'd0;
    localparam logic [2:0] MODE_FREE  = 3'd1;
    localparam logic [2:0] MODE_ENQ   = 3'd2;
    localparam logic [2:0] MODE_ACK   = 3'd3;
    localparam logic [2:0] MODE_PICK  = 3'd4;
    localparam logic [2:0] MODE_TX    = 3'd5;

    typedef enum logic [2:0] {
        ST_FREE        = 3'd0,
        ST_BUSY        = 3'd1,
        ST_WAIT_TX     = 3'd2,
        ST_WAIT_TX_ACK = 3'd3,
        ST_WAIT_ACK    = 3'd4
    } slot_state_t;

    typedef struct packed {
        slot_state_t        state;
        logic [FAIL_W-1:0]  fail;
        logic [TIME_W-1:0]  stamp;
    } slot_rec_t;

endpackage

// ===== rtl/core/tbsm_ifs.sv =====
// ----------------------------------------------------------------------------
// tbsm channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbsm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [2:0]  slot_index;
    logic        need_ack;
    logic        tx_ok;
    logic [31:0] now;

    modport source (output valid, mode, slot_index, need_ack, tx_ok, now, input ready);
    modport sink (input valid, mode, slot_index, need_ack, tx_ok, now, output ready);
endinterface

interface tbsm_rsp_if;
    logic       valid;
    logic       ready;
    logic       granted;
    logic [2:0] result_index;
    logic [2:0] slot_state;

    modport source (output valid, granted, result_index, slot_state, input ready);
    modport sink (input valid, granted, result_index, slot_state, output ready);
endinterface

interface tbsm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tbsm_pkg::CFG_IDX_W-1:0]  index;
    logic [tbsm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tx_buffer_slot_manager_top.sv =====
// The slot manager takes one request at a time and answers each with one
// response. Apart from an unknown mode code or an out-of-range slot index, a
// request walks the slot memory through its single read port, one slot per
// cycle, while one shared age unit does every time compare. Free, enqueue and
// tx result read only their own slot; ack scans up to the first slot waiting
// for an ack and pick scans every slot; allocate tries the hint slot and, when
// it is not free, scans for a free slot and then for an idle one to reclaim. A
// new request is taken as soon as the previous response has been loaded into
// the output register, even if the consumer has not yet taken it.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
// tx_buffer_slot_manager_top
// Frame buffer slot pool with hint allocation, reclaim and oldest-first pick.
// ----------------------------------------------------------------------------
module tx_buffer_slot_manager_top
#(
    parameter int SLOT_COUNT = tbsm_pkg::SLOT_COUNT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    tbsm_req_if.sink   req,
    tbsm_rsp_if.source rsp,
    tbsm_cfg_if.sink   cfg
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] LAST = CW'(SLOT_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } seq_state_t;

    typedef enum logic [2:0] {
        PH_HINT,
        PH_FREE,
        PH_RECLAIM,
        PH_ACK,
        PH_PICK,
        PH_SINGLE
    } phase_t;

    seq_state_t seq_reg, seq_next;
    phase_t     phase_reg, phase_next;

    logic [2:0]                  mode_reg, mode_next;
    logic                        need_ack_reg, need_ack_next;
    logic                        tx_ok_reg, tx_ok_next;
    logic [tbsm_pkg::TIME_W-1:0] now_reg, now_next;
    logic [CW-1:0]               issue_reg, issue_next;
    logic [CW-1:0]               end_reg, end_next;
    logic                        pend_reg, pend_next;
    logic [AW-1:0]               eval_reg, eval_next;
    logic                        hit_reg, hit_next;
    logic [AW-1:0]               tgt_reg, tgt_next;
    logic                        found_reg, found_next;
    logic [tbsm_pkg::TIME_W-1:0] best_age_reg, best_age_next;
    tbsm_pkg::slot_state_t       best_state_reg, best_state_next;
    logic [AW-1:0]               hint_reg, hint_next;
    logic [tbsm_pkg::FAIL_W-1:0] max_fail_reg, max_fail_next;
    logic [tbsm_pkg::TIME_W-1:0] max_idle_reg, max_idle_next;

    logic       out_valid_reg, out_valid_next;
    logic       out_granted_reg, out_granted_next;
    logic [2:0] out_index_reg, out_index_next;
    logic [2:0] out_state_reg, out_state_next;

    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    tbsm_pkg::slot_rec_t         rd_rec;
    logic                        wr_en;
    tbsm_pkg::slot_rec_t         wr_rec;
    logic [tbsm_pkg::TIME_W-1:0] age;
    logic                        age_over;
    logic [tbsm_pkg::TIME_W-1:0] age_limit;

    logic [CW-1:0]               req_idx;
    logic                        req_idx_ok;
    logic                        hit_now;
    logic                        out_free;
    logic [CW-1:0]               hint_inc;
    logic [CW-1:0]               tgt_inc;
    logic [tbsm_pkg::FAIL_W-1:0] fail_inc;
    tbsm_pkg::slot_state_t       new_state;
    logic                        waiting;

    tbsm_slot_store #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_rec  (rd_rec),
        .wr_en   (wr_en),
        .wr_addr (tgt_reg),
        .wr_rec  (wr_rec)
    );

    tbsm_age_unit u_age (
        .now   (now_reg),
        .stamp (rd_rec.stamp),
        .limit (age_limit),
        .age   (age),
        .over  (age_over)
    );

    assign age_limit = (phase_reg == PH_PICK) ? best_age_reg : max_idle_reg;

    assign req.ready = (seq_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted      = out_granted_reg;
    assign rsp.result_index = out_index_reg;
    assign rsp.slot_state   = out_state_reg;

    assign req_idx    = CW'({5'd0, req.slot_index});
    assign req_idx_ok = {29'd0, req.slot_index} < 32'(SLOT_COUNT);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign rd_addr    = issue_reg[AW-1:0];
    assign waiting    = (rd_rec.state inside {tbsm_pkg::ST_WAIT_TX, tbsm_pkg::ST_WAIT_TX_ACK});

    assign hint_inc = CW'(hint_reg) + CW'(1);
    assign tgt_inc  = CW'(tgt_reg) + CW'(1);
    assign fail_inc = (rd_rec.fail == '1) ? rd_rec.fail : rd_rec.fail + 8'd1;

    always_comb
    begin
        seq_next        = seq_reg;
        phase_next      = phase_reg;
        mode_next       = mode_reg;
        need_ack_next   = need_ack_reg;
        tx_ok_next      = tx_ok_reg;
        now_next        = now_reg;
        issue_next      = issue_reg;
        end_next        = end_reg;
        pend_next       = pend_reg;
        eval_next       = eval_reg;
        hit_next        = hit_reg;
        tgt_next        = tgt_reg;
        found_next      = found_reg;
        best_age_next   = best_age_reg;
        best_state_next = best_state_reg;
        hint_next       = hint_reg;
        max_fail_next   = max_fail_reg;
        max_idle_next   = max_idle_reg;

        out_valid_next   = out_valid_reg;
        out_granted_next = out_granted_reg;
        out_index_next   = out_index_reg;
        out_state_next   = out_state_reg;

        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_rec    = rd_rec;
        hit_now   = 1'b0;
        new_state = tbsm_pkg::ST_FREE;

        if (cfg.valid)
        begin
            if (cfg.index == tbsm_pkg::CFG_MAX_FAIL)
            begin
                max_fail_next = cfg.data[tbsm_pkg::FAIL_W-1:0];
            end
            else if (cfg.index == tbsm_pkg::CFG_MAX_IDLE)
            begin
                max_idle_next = cfg.data[tbsm_pkg::TIME_W-1:0];
            end
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (seq_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next     = req.mode;
                    need_ack_next = req.need_ack;
                    tx_ok_next    = req.tx_ok;
                    now_next      = req.now;
                    pend_next     = 1'b0;
                    found_next    = 1'b0;
                    hit_next      = 1'b0;
                    tgt_next      = '0;
                    issue_next    = '0;
                    end_next      = LAST;
                    seq_next      = S_WRITE;
                    case (req.mode)
                        tbsm_pkg::MODE_ALLOC:
                        begin
                            phase_next = PH_HINT;
                            issue_next = CW'(hint_reg);
                            end_next   = hint_inc;
                            seq_next   = S_SCAN;
                        end
                        tbsm_pkg::MODE_FREE, tbsm_pkg::MODE_ENQ, tbsm_pkg::MODE_TX:
                        begin
                            if (req_idx_ok)
                            begin
                                phase_next = PH_SINGLE;
                                issue_next = req_idx;
                                end_next   = req_idx + CW'(1);
                                seq_next   = S_SCAN;
                            end
                        end
                        tbsm_pkg::MODE_ACK:
                        begin
                            phase_next = PH_ACK;
                            seq_next   = S_SCAN;
                        end
                        tbsm_pkg::MODE_PICK:
                        begin
                            phase_next = PH_PICK;
                            seq_next   = S_SCAN;
                        end
                        default:
                        begin
                            seq_next = S_WRITE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Evaluate the slot read in the previous cycle.
                if (pend_reg)
                begin
                    case (phase_reg)
                        PH_HINT, PH_FREE: hit_now = (rd_rec.state == tbsm_pkg::ST_FREE);
                        PH_RECLAIM:       hit_now = age_over;
                        PH_ACK:           hit_now = (rd_rec.state == tbsm_pkg::ST_WAIT_ACK);
                        PH_SINGLE:        hit_now = 1'b1;
                        PH_PICK:
                        begin
                            if (waiting && (!found_reg || age_over))
                            begin
                                found_next      = 1'b1;
                                tgt_next        = eval_reg;
                                best_age_next   = age;
                                best_state_next = rd_rec.state;
                            end
                        end
                        default: hit_now = 1'b0;
                    endcase
                end

                if (hit_now)
                begin
                    // The read port stays idle so the hit record is held for the write.
                    tgt_next  = eval_reg;
                    hit_next  = 1'b1;
                    pend_next = 1'b0;
                    seq_next  = S_WRITE;
                end
                else if (issue_reg != end_reg)
                begin
                    rd_en      = 1'b1;
                    pend_next  = 1'b1;
                    eval_next  = issue_reg[AW-1:0];
                    issue_next = issue_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        case (phase_reg)
                            PH_HINT:
                            begin
                                phase_next = PH_FREE;
                                issue_next = '0;
                                end_next   = LAST;
                            end
                            PH_FREE:
                            begin
                                phase_next = PH_RECLAIM;
                                issue_next = '0;
                                end_next   = LAST;
                            end
                            PH_PICK:
                            begin
                                hit_next = found_reg;
                                seq_next = S_WRITE;
                            end
                            default:
                            begin
                                hit_next = 1'b0;
                                seq_next = S_WRITE;
                            end
                        endcase
                    end
                end
            end

            S_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = 1'b0;
                    out_index_next   = '0;
                    out_state_next   = '0;
                    seq_next         = S_IDLE;
                    if (hit_reg)
                    begin
                        out_granted_next = 1'b1;
                        case (mode_reg)
                            tbsm_pkg::MODE_ALLOC:
                            begin
                                new_state = tbsm_pkg::ST_BUSY;
                                wr_rec    = '{tbsm_pkg::ST_BUSY, '0, now_reg};
                                wr_en     = 1'b1;
                                if (phase_reg == PH_HINT)
                                begin
                                    hint_next = (hint_inc == LAST) ? '0 : hint_inc[AW-1:0];
                                end
                            end
                            tbsm_pkg::MODE_FREE:
                            begin
                                new_state    = tbsm_pkg::ST_FREE;
                                wr_rec.state = tbsm_pkg::ST_FREE;
                                wr_en        = 1'b1;
                                // Hint rewinds when it sits just past the freed slot.
                                if (CW'(hint_reg) == ((tgt_inc == LAST) ? '0 : tgt_inc))
                                begin
                                    hint_next = tgt_reg;
                                end
                            end
                            tbsm_pkg::MODE_ENQ:
                            begin
                                new_state    = need_ack_reg ? tbsm_pkg::ST_WAIT_TX_ACK
                                                            : tbsm_pkg::ST_WAIT_TX;
                                wr_rec.state = new_state;
                                wr_rec.stamp = now_reg;
                                wr_en        = 1'b1;
                            end
                            tbsm_pkg::MODE_ACK:
                            begin
                                new_state    = tbsm_pkg::ST_FREE;
                                wr_rec.state = tbsm_pkg::ST_FREE;
                                wr_en        = 1'b1;
                            end
                            tbsm_pkg::MODE_PICK:
                            begin
                                new_state = best_state_reg;
                            end
                            tbsm_pkg::MODE_TX:
                            begin
                                if (waiting)
                                begin
                                    wr_rec.stamp = now_reg;
                                    if (tx_ok_reg)
                                    begin
                                        new_state = (rd_rec.state == tbsm_pkg::ST_WAIT_TX_ACK)
                                                    ? tbsm_pkg::ST_WAIT_ACK : tbsm_pkg::ST_FREE;
                                    end
                                    else
                                    begin
                                        wr_rec.fail = fail_inc;
                                        new_state   = (fail_inc > max_fail_reg)
                                                      ? tbsm_pkg::ST_FREE : rd_rec.state;
                                    end
                                    wr_rec.state = new_state;
                                    wr_en        = 1'b1;
                                end
                                else
                                begin
                                    out_granted_next = 1'b0;
                                end
                            end
                            default:
                            begin
                                out_granted_next = 1'b0;
                            end
                        endcase
                        if (out_granted_next)
                        begin
                            out_index_next = 3'(tgt_reg);
                            out_state_next = new_state;
                        end
                    end
                end
            end

            default:
            begin
                seq_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= S_IDLE;
            phase_reg       <= PH_HINT;
            mode_reg        <= '0;
            need_ack_reg    <= 1'b0;
            tx_ok_reg       <= 1'b0;
            now_reg         <= '0;
            issue_reg       <= '0;
            end_reg         <= '0;
            pend_reg        <= 1'b0;
            eval_reg        <= '0;
            hit_reg         <= 1'b0;
            tgt_reg         <= '0;
            found_reg       <= 1'b0;
            best_age_reg    <= '0;
            best_state_reg  <= tbsm_pkg::ST_FREE;
            hint_reg        <= '0;
            max_fail_reg    <= tbsm_pkg::MAX_FAIL_RST;
            max_idle_reg    <= tbsm_pkg::MAX_IDLE_RST;
            out_valid_reg   <= 1'b0;
            out_granted_reg <= 1'b0;
            out_index_reg   <= '0;
            out_state_reg   <= '0;
        end
        else
        begin
            seq_reg         <= seq_next;
            phase_reg       <= phase_next;
            mode_reg        <= mode_next;
            need_ack_reg    <= need_ack_next;
            tx_ok_reg       <= tx_ok_next;
            now_reg         <= now_next;
            issue_reg       <= issue_next;
            end_reg         <= end_next;
            pend_reg        <= pend_next;
            eval_reg        <= eval_next;
            hit_reg         <= hit_next;
            tgt_reg         <= tgt_next;
            found_reg       <= found_next;
            best_age_reg    <= best_age_next;
            best_state_reg  <= best_state_next;
            hint_reg        <= hint_next;
            max_fail_reg    <= max_fail_next;
            max_idle_reg    <= max_idle_next;
            out_valid_reg   <= out_valid_next;
            out_granted_reg <= out_granted_next;
            out_index_reg   <= out_index_next;
            out_state_reg   <= out_state_next;
        end
    end

endmodule

// ===== rtl/core/tbsm_age_unit.sv =====
// ----------------------------------------------------------------------------
// tbsm_age_unit
// Shared age unit: age of a slot modulo 2^32 and compare against a limit.
// ----------------------------------------------------------------------------
module tbsm_age_unit
(
    input  logic [tbsm_pkg::TIME_W-1:0] now,
    input  logic [tbsm_pkg::TIME_W-1:0] stamp,
    input  logic [tbsm_pkg::TIME_W-1:0] limit,
    output logic [tbsm_pkg::TIME_W-1:0] age,
    output logic                        over
);

    assign age  = now - stamp;
    assign over = age > limit;

endmodule

// ===== rtl/core/tbsm_slot_store.sv =====
// ----------------------------------------------------------------------------
// tbsm_slot_store
// Slot record memory with one registered read port, one write port and a
// written flag per slot so that unwritten slots read as free with no failures.
// ----------------------------------------------------------------------------
module tbsm_slot_store
#(
    parameter int SLOT_COUNT = tbsm_pkg::SLOT_COUNT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
    output tbsm_pkg::slot_rec_t           rd_rec,
    input  logic                          wr_en,
    input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
    input  tbsm_pkg::slot_rec_t           wr_rec
);

    tbsm_pkg::slot_rec_t mem [SLOT_COUNT];
    tbsm_pkg::slot_rec_t rd_data_reg;
    logic [SLOT_COUNT-1:0] written_reg;
    logic                  rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_rec;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    always_comb
    begin
        rd_rec = rd_data_reg;
        if (!rd_written_reg)
        begin
            rd_rec.state = tbsm_pkg::ST_FREE;
            rd_rec.fail  = '0;
        end
    end

endmodule

// ===== tb/tb_tx_buffer_slot_manager_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tx_buffer_slot_manager_top
// Drives slot pool requests in random bursts against a stalling consumer,
// predicts every response from a local model of the pool and compares each
// response field by field, across several register settings.
// ----------------------------------------------------------------------------
module tb_tx_buffer_slot_manager_top;

    import tbsm_pkg::*;

    localparam int SLOTS         = SLOT_COUNT_DEF;
    localparam int LONG_HOLD     = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 30;
    localparam int PRINT_CAP     = 100;

    // Codes that the block must ignore.
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  slot;
        logic        need_ack;
        logic        tx_ok;
        logic [31:0] tick;
    } pool_request_t;

    typedef struct packed {
        logic        granted;
        logic [2:0]  idx;
        slot_state_t state;
    } pool_response_t;

    logic clk = 1'b0;
    logic rst_n;

    tbsm_req_if req_ch ();
    tbsm_rsp_if rsp_ch ();
    tbsm_cfg_if cfg_ch ();

    tx_buffer_slot_manager_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #1 clk = ~clk;

    // Local copy of the pool and its registers.
    slot_state_t  pool_state [SLOTS];
    logic [31:0]  pool_stamp [SLOTS];
    logic [7:0]   pool_fails [SLOTS];
    int           alloc_next;
    logic [7:0]   fail_limit = MAX_FAIL_RST;
    logic [31:0]  idle_limit = MAX_IDLE_RST;

    pool_request_t  pending_requests [$];
    pool_response_t expected_responses [$];

    int          mismatches = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          hold_requests = 0;
    int          holds_done = 0;
    int          quiet_cycles = 0;
    int          queued_total = 0;
    logic [5:0]  stall_phase = '0;
    logic [15:0] stall_mask = '1;
    logic [31:0] tick_now = '0;
    int          max_step = 0;
    pool_response_t want;

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic pool_response_t apply_request(pool_request_t rq);
        pool_response_t r;
        int             sel;
        logic [31:0]    age;
        logic [31:0]    best_age;
        r = '0;
        sel = -1;
        best_age = '0;
        case (rq.op)
            MODE_ALLOC:
            begin
                if (pool_state[alloc_next] == ST_FREE)
                begin
                    sel = alloc_next;
                    alloc_next = (alloc_next + 1) % SLOTS;
                end
                for (int i = 0; i < SLOTS; i++)
                    if (sel < 0 && pool_state[i] == ST_FREE)
                        sel = i;
                for (int i = 0; i < SLOTS; i++)
                begin
                    age = rq.tick - pool_stamp[i];
                    if (sel < 0 && age > idle_limit)
                        sel = i;
                end
                if (sel >= 0)
                begin
                    pool_state[sel] = ST_BUSY;
                    pool_fails[sel] = '0;
                    pool_stamp[sel] = rq.tick;
                end
            end
            MODE_FREE:
            begin
                sel = rq.slot;
                pool_state[sel] = ST_FREE;
                if (alloc_next == (sel + 1) % SLOTS)
                    alloc_next = sel;
            end
            MODE_ENQ:
            begin
                sel = rq.slot;
                pool_state[sel] = rq.need_ack ? ST_WAIT_TX_ACK : ST_WAIT_TX;
                pool_stamp[sel] = rq.tick;
            end
            MODE_ACK:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (sel < 0 && pool_state[i] == ST_WAIT_ACK)
                        sel = i;
                if (sel >= 0)
                    pool_state[sel] = ST_FREE;
            end
            MODE_PICK:
            begin
                // Strictly greater age wins, so ties keep the lowest slot.
                for (int i = 0; i < SLOTS; i++)
                begin
                    age = rq.tick - pool_stamp[i];
                    if ((pool_state[i] == ST_WAIT_TX || pool_state[i] == ST_WAIT_TX_ACK)
                        && (sel < 0 || age > best_age))
                    begin
                        sel = i;
                        best_age = age;
                    end
                end
            end
            MODE_TX:
            begin
                if (pool_state[rq.slot] == ST_WAIT_TX || pool_state[rq.slot] == ST_WAIT_TX_ACK)
                begin
                    sel = rq.slot;
                    pool_stamp[sel] = rq.tick;
                    if (rq.tx_ok)
                        pool_state[sel] = (pool_state[sel] == ST_WAIT_TX_ACK) ? ST_WAIT_ACK
                                                                               : ST_FREE;
                    else
                    begin
                        if (pool_fails[sel] != 8'hFF)
                            pool_fails[sel] = pool_fails[sel] + 8'd1;
                        if (pool_fails[sel] > fail_limit)
                            pool_state[sel] = ST_FREE;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (sel >= 0)
        begin
            r.granted = 1'b1;
            r.idx = sel[2:0];
            r.state = pool_state[sel];
        end
        return r;
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.mode <= '0;
            req_ch.slot_index <= '0;
            req_ch.need_ack <= 1'b0;
            req_ch.tx_ok <= 1'b0;
            req_ch.now <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_responses.push_back(apply_request(pending_requests.pop_front()));
            if (req_ch.valid && !req_ch.ready)
            begin
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                req_ch.valid <= 1'b1;
                req_ch.mode <= pending_requests[0].op;
                req_ch.slot_index <= pending_requests[0].slot;
                req_ch.need_ack <= pending_requests[0].need_ack;
                req_ch.tx_ok <= pending_requests[0].tx_ok;
                req_ch.now <= pending_requests[0].tick;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response consumer: a rotating stall mask, with a long hold on demand.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
            if (hold_left == 1)
                holds_done <= holds_done + 1;
        end
        else if (holds_done != hold_requests)
        begin
            hold_left <= LONG_HOLD;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            stall_phase <= stall_phase + 6'd1;
            if (stall_phase == '1)
                stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            else
                stall_mask <= {stall_mask[0], stall_mask[15:1]};
            rsp_ch.ready <= stall_mask[0];
        end
    end

    // Response checker.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_responses.size() == 0)
                report_mismatch("response with no request outstanding");
            else
            begin
                want = expected_responses.pop_front();
                if (rsp_ch.granted !== want.granted)
                    report_mismatch($sformatf("granted %b, expected %b",
                                              rsp_ch.granted, want.granted));
                if (rsp_ch.result_index !== want.idx)
                    report_mismatch($sformatf("result_index %0d, expected %0d",
                                              rsp_ch.result_index, want.idx));
                if (rsp_ch.slot_state !== want.state)
                    report_mismatch($sformatf("slot_state %0d, expected %0d",
                                              rsp_ch.slot_state, want.state));
            end
        end
    end

    // Register mirror.
    always @(posedge clk)
    begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            if (cfg_ch.index == CFG_MAX_FAIL)
                fail_limit <= cfg_ch.data[7:0];
            else if (cfg_ch.index == CFG_MAX_IDLE)
                idle_limit <= cfg_ch.data;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic push_request(logic [2:0] op, logic [2:0] slot, logic need_ack,
                                logic tx_ok, logic [31:0] tick);
        pending_requests.push_back('{op: op, slot: slot, need_ack: need_ack,
                                     tx_ok: tx_ok, tick: tick});
        queued_total++;
    endtask

    task automatic push_timed(logic [2:0] op, logic [2:0] slot, logic need_ack,
                              logic tx_ok);
        tick_now = tick_now + 32'($urandom_range(0, max_step));
        push_request(op, slot, need_ack, tx_ok, tick_now);
    endtask

    // One frame going through the pool, on a random slot.
    task automatic queue_frame_cycle();
        logic [2:0] slot;
        logic       ack;
        logic       ok;
        int         retries;
        slot = 3'($urandom_range(0, SLOTS - 1));
        ack = 1'($urandom);
        ok = 1'b0;
        retries = $urandom_range(0, 4);
        push_timed(MODE_ALLOC, 3'($urandom), 1'($urandom), 1'($urandom));
        push_timed(MODE_ENQ, slot, ack, 1'($urandom));
        if ($urandom_range(0, 1) == 0)
            push_timed(MODE_PICK, 3'($urandom), 1'($urandom), 1'($urandom));
        for (int i = 0; i <= retries && !ok; i++)
        begin
            ok = (i == retries) ? 1'($urandom_range(0, 3) != 0) : 1'b0;
            push_timed(MODE_TX, slot, 1'($urandom), ok);
        end
        if (ack && ok && $urandom_range(0, 9) < 7)
            push_timed(MODE_ACK, 3'($urandom), 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 9) < 3)
            push_timed(MODE_FREE, slot, 1'($urandom), 1'($urandom));
    endtask

    task automatic queue_noise();
        if ($urandom_range(0, 19) == 0)
            tick_now = $urandom;
        push_timed(3'($urandom), 3'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Drive one slot's fail count up to saturation; a limit of 255 keeps it waiting.
    task automatic queue_retry_storm();
        push_timed(MODE_ENQ, 3'd4, 1'b1, 1'b0);
        for (int i = 0; i < 258; i++)
            push_timed(MODE_TX, 3'd4, 1'b0, 1'b0);
        push_timed(MODE_TX, 3'd4, 1'b0, 1'b1);
        push_timed(MODE_ACK, 3'd0, 1'b0, 1'b0);
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || expected_responses.size() != 0
               || req_ch.valid);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(logic [7:0] fails, logic [31:0] idle, int count,
                             int step, bit long_hold, bit storm);
        int target;
        settle();
        // Upper data bits are junk for the 8-bit register.
        write_reg(CFG_MAX_FAIL, ($urandom & 32'hFFFF_FF00) | 32'(fails));
        write_reg(CFG_MAX_IDLE, idle);
        tick_now = $urandom;
        max_step = step;
        if (long_hold)
            hold_requests++;
        if (storm)
            queue_retry_storm();
        target = queued_total + count;
        while (queued_total < target)
        begin
            if ($urandom_range(0, 9) < 7)
                queue_frame_cycle();
            else
                queue_noise();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            pool_state[i] = ST_FREE;
            pool_stamp[i] = '0;
            pool_fails[i] = '0;
        end
        alloc_next = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty pool, ignored codes, and a free that pulls the hint back
        // across the wrap.
        push_request(MODE_PICK, 3'd0, 1'b0, 1'b0, 32'd0);
        push_request(MODE_ACK, 3'd0, 1'b0, 1'b0, 32'd0);
        push_request(MODE_TX, 3'd0, 1'b1, 1'b1, 32'd0);
        push_request(MODE_SPARE_6, 3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF);
        push_request(MODE_SPARE_7, 3'd7, 1'b1, 1'b0, 32'hFFFF_FFFF);
        push_request(MODE_FREE, 3'd7, 1'b0, 1'b0, 32'd0);
        for (int i = 0; i < SLOTS; i++)
            push_request(MODE_ALLOC, 3'd0, 1'b0, 1'b0, 32'd0);
        // Full pool: an age equal to the limit is not enough, one more is.
        push_request(MODE_ALLOC, 3'd0, 1'b0, 1'b0, 32'd1000);
        push_request(MODE_ALLOC, 3'd0, 1'b0, 1'b0, 32'd1001);
        push_request(MODE_ENQ, 3'd3, 1'b1, 1'b0, 32'hFFFF_FFFF);
        push_request(MODE_ENQ, 3'd5, 1'b0, 1'b0, 32'hFFFF_FFF0);
        push_request(MODE_PICK, 3'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        push_request(MODE_TX, 3'd5, 1'b0, 1'b0, 32'hFFFF_FFFF);
        push_request(MODE_TX, 3'd5, 1'b0, 1'b1, 32'd2);
        push_request(MODE_TX, 3'd3, 1'b0, 1'b1, 32'd3);
        push_request(MODE_ACK, 3'd0, 1'b0, 1'b0, 32'd4);
        push_request(MODE_FREE, 3'd6, 1'b0, 1'b0, 32'd5);
        push_request(MODE_ALLOC, 3'd0, 1'b0, 1'b0, 32'd6);

        run_phase(8'd0, 32'd0, 200, 3, 1'b0, 1'b0);
        run_phase(8'd255, 32'hFFFF_FFFF, 200, 50, 1'b0, 1'b1);
        run_phase(8'd3, 32'd40, 200, 10, 1'b0, 1'b0);
        run_phase(8'($urandom), 32'($urandom_range(0, 200)), 200, 20, 1'b0, 1'b0);
        run_phase(8'd1, 32'd200, 200, 30, 1'b1, 1'b0);
        run_phase(8'($urandom), $urandom, 200, 1 << 30, 1'b0, 1'b0);

        settle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
